// ===== rtl/spmo_pkg.sv =====
// Shared widths, defaults and output limits for the 3x3 subpixel offset block.
package spmo_pkg;

    // Port field widths
    localparam int COST_W = 16;
    localparam int OFF_W  = 16;

    // Parameter defaults for the top level
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Quotient magnitude bits: one more than the offset so clipping can be seen
    localparam int QUO_W = OFF_W + 1;

    // Offset clip limits
    localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

endpackage

// ===== rtl/spmo_nbr_if.sv =====
// Neighborhood input channel: valid/ready handshake with nine cost values.
interface spmo_nbr_if;
    import spmo_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] cost_up_left;
    logic [COST_W-1:0] cost_up;
    logic [COST_W-1:0] cost_up_right;
    logic [COST_W-1:0] cost_left;
    logic [COST_W-1:0] cost_center;
    logic [COST_W-1:0] cost_right;
    logic [COST_W-1:0] cost_down_left;
    logic [COST_W-1:0] cost_down;
    logic [COST_W-1:0] cost_down_right;

    modport source (
        output valid,
        output cost_up_left, cost_up, cost_up_right,
        output cost_left, cost_center, cost_right,
        output cost_down_left, cost_down, cost_down_right,
        input  ready
    );

    modport sink (
        input  valid,
        input  cost_up_left, cost_up, cost_up_right,
        input  cost_left, cost_center, cost_right,
        input  cost_down_left, cost_down, cost_down_right,
        output ready
    );
endinterface

// ===== rtl/spmo_off_if.sv =====
// Offset result channel: valid/ready handshake with offsets and status flags.
interface spmo_off_if;
    import spmo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic                    zero_denominator;
    logic                    saturated;

    modport source (
        output valid,
        output offset_x, offset_y, zero_denominator, saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  offset_x, offset_y, zero_denominator, saturated,
        output ready
    );
endinterface

// ===== rtl/subpixel_min_offset_3x3.sv =====
// Parabolic subpixel minimum offset on a 3x3 cost neighborhood: takes one transaction per
// clock unless the output stalls and returns one result transaction per input, in order.
// The core of the pipeline is the pair of restoring divider lanes (x and y),
// which retire one quotient bit per stage over 17 stages; ahead of them sit four stages for
// the column/row sums, the denominator 12*center - 2*sum, the magnitudes and the range check,
// and behind them one output register with sign and clipping. Each stage holds its
// transaction until the next one frees up, so a stall on the output fills the pipe without
// dropping anything. Offsets are signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero and clipped to 16 bits; a zero denominator reports zero offsets and no clip.
module subpixel_min_offset_3x3 #(
    parameter int SAMPLE_BITS = spmo_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = spmo_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spmo_nbr_if.sink   i_nbr,
    spmo_off_if.source o_off
);
    import spmo_pkg::*;

    // Widths
    localparam int SW     = (SAMPLE_BITS < COST_W) ? SAMPLE_BITS : COST_W;
    localparam int PW     = SW + 2;              // three-term partial sum
    localparam int SUM_W  = SW + 4;              // sum of all nine
    localparam int DW     = SW + 5;              // signed denominator
    localparam int NW     = SW + 3;              // signed numerator
    localparam int MW     = SW + 4;              // denominator magnitude
    localparam int NMW    = SW + 2;              // numerator magnitude
    localparam int RW     = MW + QUO_W - 1;      // remainder / shifted divisor
    localparam int OVF_SH = QUO_W - FRAC_BITS;   // divisor shift for the range check

    // Stage indexes
    localparam int NDIV = QUO_W;
    localparam int NS   = NDIV + 5;
    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_C = 2;
    localparam int ST_D = 3;
    localparam int ST_O = NS - 1;

    typedef struct packed {
        logic [MW-1:0]    den_mag;
        logic [RW-1:0]    rem_x;
        logic [RW-1:0]    rem_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             zero;
    } t_div;

    // Sign and clip one quotient magnitude; returns {clipped, value}
    function automatic logic [OFF_W:0] clip_offset(
        input logic [QUO_W-1:0] mag,
        input logic             neg,
        input logic             ovf
    );
        logic [QUO_W-1:0] neg_mag;
        logic [OFF_W:0]   res;
        neg_mag = -mag;
        if (neg) begin
            if (ovf || (mag > (QUO_W'(1) << (OFF_W - 1)))) begin
                res = {1'b1, OFF_MIN};
            end else begin
                res = {1'b0, neg_mag[OFF_W-1:0]};
            end
        end else begin
            if (ovf || (mag > QUO_W'(OFF_MAX))) begin
                res = {1'b1, OFF_MAX};
            end else begin
                res = {1'b0, mag[OFF_W-1:0]};
            end
        end
        return res;
    endfunction

    // Stage valid bits and per-stage advance
    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[ST_O] = !r_vld[ST_O] || o_off.ready;
        for (int s = NS - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign i_nbr.ready = adv[ST_A];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[ST_A]) begin
                r_vld[ST_A] <= i_nbr.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage A: masked samples, column and row sums
    logic [SW-1:0] c0, c1, c2, c3, c4, c5, c6, c7, c8;
    logic [PW-1:0] r_col_l, r_col_m, r_col_r, r_row_t, r_row_b;
    logic [SW-1:0] r_ctr;

    assign c0 = i_nbr.cost_up_left[SW-1:0];
    assign c1 = i_nbr.cost_up[SW-1:0];
    assign c2 = i_nbr.cost_up_right[SW-1:0];
    assign c3 = i_nbr.cost_left[SW-1:0];
    assign c4 = i_nbr.cost_center[SW-1:0];
    assign c5 = i_nbr.cost_right[SW-1:0];
    assign c6 = i_nbr.cost_down_left[SW-1:0];
    assign c7 = i_nbr.cost_down[SW-1:0];
    assign c8 = i_nbr.cost_down_right[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (adv[ST_A]) begin
            r_col_l <= PW'(c0) + PW'(c3) + PW'(c6);
            r_col_m <= PW'(c1) + PW'(c4) + PW'(c7);
            r_col_r <= PW'(c2) + PW'(c5) + PW'(c8);
            r_row_t <= PW'(c0) + PW'(c1) + PW'(c2);
            r_row_b <= PW'(c6) + PW'(c7) + PW'(c8);
            r_ctr   <= c4;
        end
    end

    // Stage B: denominator and numerators
    logic [SUM_W-1:0]     sum_all;
    logic [DW-1:0]        ctr12;
    logic signed [DW-1:0] r_den;
    logic signed [NW-1:0] r_nx, r_ny;

    assign sum_all = SUM_W'(r_col_l) + SUM_W'(r_col_m) + SUM_W'(r_col_r);
    assign ctr12   = (DW'(r_ctr) << 3) + (DW'(r_ctr) << 2);

    always_ff @(posedge i_clk) begin
        if (adv[ST_B]) begin
            r_den <= $signed(ctr12 - {sum_all, 1'b0});
            r_nx  <= $signed(NW'(r_col_r) - NW'(r_col_l));
            r_ny  <= $signed(NW'(r_row_b) - NW'(r_row_t));
        end
    end

    // Stage C: magnitudes, quotient signs, zero check
    logic [DW-1:0]  den_abs;
    logic [NW-1:0]  nx_abs, ny_abs;
    logic [MW-1:0]  r_den_mag;
    logic [NMW-1:0] r_nx_mag, r_ny_mag;
    logic           r_neg_x, r_neg_y, r_zero;

    assign den_abs = r_den[DW-1] ? -r_den : r_den;
    assign nx_abs  = r_nx[NW-1] ? -r_nx : r_nx;
    assign ny_abs  = r_ny[NW-1] ? -r_ny : r_ny;

    always_ff @(posedge i_clk) begin
        if (adv[ST_C]) begin
            r_den_mag <= den_abs[MW-1:0];
            r_nx_mag  <= nx_abs[NMW-1:0];
            r_ny_mag  <= ny_abs[NMW-1:0];
            r_neg_x   <= r_nx[NW-1] ^ r_den[DW-1];
            r_neg_y   <= r_ny[NW-1] ^ r_den[DW-1];
            r_zero    <= (r_den == '0);
        end
    end

    // Stage D: scaled dividends and quotient range check
    t_div r_div [NDIV+1];
    t_div n_div0;
    logic [RW-1:0] ovf_lim;

    assign ovf_lim = RW'(r_den_mag) << OVF_SH;

    always_comb begin
        n_div0         = '0;
        n_div0.den_mag = r_den_mag;
        n_div0.rem_x   = RW'(r_nx_mag) << FRAC_BITS;
        n_div0.rem_y   = RW'(r_ny_mag) << FRAC_BITS;
        n_div0.neg_x   = r_neg_x;
        n_div0.neg_y   = r_neg_y;
        n_div0.ovf_x   = (RW'(r_nx_mag) >= ovf_lim);
        n_div0.ovf_y   = (RW'(r_ny_mag) >= ovf_lim);
        n_div0.zero    = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_D]) begin
            r_div[0] <= n_div0;
        end
    end

    // Restoring division: one quotient bit per stage, most significant first
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int SH = NDIV - 1 - j;
        logic [RW-1:0] dsh;
        t_div          n_step;

        assign dsh = RW'(r_div[j].den_mag) << SH;

        always_comb begin
            n_step = r_div[j];
            if (r_div[j].rem_x >= dsh) begin
                n_step.rem_x     = r_div[j].rem_x - dsh;
                n_step.quo_x[SH] = 1'b1;
            end
            if (r_div[j].rem_y >= dsh) begin
                n_step.rem_y     = r_div[j].rem_y - dsh;
                n_step.quo_y[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[ST_D+j+1]) begin
                r_div[j+1] <= n_step;
            end
        end
    end

    // Output stage: sign, clip, zero-denominator override
    logic [OFF_W:0]          clip_x, clip_y;
    logic signed [OFF_W-1:0] r_off_x, r_off_y;
    logic                    r_out_zero, r_out_sat;

    assign clip_x = clip_offset(r_div[NDIV].quo_x, r_div[NDIV].neg_x, r_div[NDIV].ovf_x);
    assign clip_y = clip_offset(r_div[NDIV].quo_y, r_div[NDIV].neg_y, r_div[NDIV].ovf_y);

    always_ff @(posedge i_clk) begin
        if (adv[ST_O]) begin
            if (r_div[NDIV].zero) begin
                r_off_x    <= '0;
                r_off_y    <= '0;
                r_out_zero <= 1'b1;
                r_out_sat  <= 1'b0;
            end else begin
                r_off_x    <= $signed(clip_x[OFF_W-1:0]);
                r_off_y    <= $signed(clip_y[OFF_W-1:0]);
                r_out_zero <= 1'b0;
                r_out_sat  <= clip_x[OFF_W] | clip_y[OFF_W];
            end
        end
    end

    assign o_off.valid            = r_vld[ST_O];
    assign o_off.offset_x         = r_off_x;
    assign o_off.offset_y         = r_off_y;
    assign o_off.zero_denominator = r_out_zero;
    assign o_off.saturated        = r_out_sat;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for subpixel_min_offset_3x3: directed and random neighborhoods.
module tb;
    import spmo_pkg::*;

    localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int COST_MAX     = (1 << COST_W) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;

    // Neighborhood positions, row-major
    localparam int P_UL = 0;
    localparam int P_U  = 1;
    localparam int P_UR = 2;
    localparam int P_L  = 3;
    localparam int P_C  = 4;
    localparam int P_R  = 5;
    localparam int P_DL = 6;
    localparam int P_D  = 7;
    localparam int P_DR = 8;

    // Random neighborhood shapes
    typedef enum int {
        SHAPE_ANY,
        SHAPE_VALLEY,
        SHAPE_FLAT_DEN,
        SHAPE_NEAR_FLAT,
        SHAPE_TINY,
        SHAPE_RAILS
    } t_shape;

    typedef logic [8:0][COST_W-1:0] t_nbr;

    typedef struct packed {
        logic signed [OFF_W-1:0] offset_x;
        logic signed [OFF_W-1:0] offset_y;
        logic                    zero_denominator;
        logic                    saturated;
    } t_offsets;

    logic clk = 1'b0;
    logic rst_n;

    spmo_nbr_if nbr ();
    spmo_off_if off ();

    subpixel_min_offset_3x3 #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_nbr   (nbr),
        .o_off   (off)
    );

    t_offsets pending_offsets[$];
    int       mismatches = 0;
    int       cycles     = 0;
    bit       tx_quiet   = 1'b0;
    bit       rx_quiet   = 1'b0;
    int       rx_hold_req = 0;

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_offsets.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Truncating fixed-point quotient clipped to the offset range
    function automatic logic signed [OFF_W-1:0] clipped_quotient(input longint num,
                                                                 input longint den,
                                                                 inout logic clipped);
        longint q;
        q = (num * (longint'(1) << FRAC_BITS)) / den;
        if (q > longint'(OFF_MAX)) begin
            clipped = 1'b1;
            return OFF_MAX;
        end
        if (q < longint'(OFF_MIN)) begin
            clipped = 1'b1;
            return OFF_MIN;
        end
        return q[OFF_W-1:0];
    endfunction

    // Parabolic peak offsets of one neighborhood
    function automatic t_offsets peak_offsets(input t_nbr n);
        longint   c[9];
        longint   total;
        longint   den;
        longint   nx;
        longint   ny;
        logic     clipped;
        t_offsets r;
        total = 0;
        for (int i = 0; i < 9; i++) begin
            c[i]  = longint'(n[i]) & ((longint'(1) << SAMPLE_BITS) - 1);
            total += c[i];
        end
        den = 12 * c[P_C] - 2 * total;
        nx  = (c[P_UR] + c[P_R] + c[P_DR]) - (c[P_UL] + c[P_L] + c[P_DL]);
        ny  = (c[P_DL] + c[P_D] + c[P_DR]) - (c[P_UL] + c[P_U] + c[P_UR]);
        r       = '0;
        clipped = 1'b0;
        if (den == 0) begin
            r.zero_denominator = 1'b1;
        end else begin
            r.offset_x  = clipped_quotient(nx, den, clipped);
            r.offset_y  = clipped_quotient(ny, den, clipped);
            r.saturated = clipped;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    always @(posedge clk) begin : check_offsets
        t_offsets exp_off;
        if (rst_n && off.valid && off.ready) begin
            if (pending_offsets.size() == 0) begin
                $display("%0t: result with none expected: x=%0d y=%0d zero=%0b sat=%0b",
                         $time, off.offset_x, off.offset_y, off.zero_denominator,
                         off.saturated);
                mismatches++;
            end else begin
                exp_off = pending_offsets.pop_front();
                if (off.offset_x !== exp_off.offset_x) begin
                    $display("%0t: offset_x expected %0d actual %0d", $time,
                             exp_off.offset_x, off.offset_x);
                    mismatches++;
                end
                if (off.offset_y !== exp_off.offset_y) begin
                    $display("%0t: offset_y expected %0d actual %0d", $time,
                             exp_off.offset_y, off.offset_y);
                    mismatches++;
                end
                if (off.zero_denominator !== exp_off.zero_denominator) begin
                    $display("%0t: zero_denominator expected %0b actual %0b", $time,
                             exp_off.zero_denominator, off.zero_denominator);
                    mismatches++;
                end
                if (off.saturated !== exp_off.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             exp_off.saturated, off.saturated);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ---------------------------------------------------------------
    initial begin : result_ready
        int stall_left;
        int r;
        stall_left = 0;
        off.ready  = 1'b0;
        forever begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (stall_left > 0) begin
                off.ready <= 1'b0;
                stall_left--;
            end else if (rx_hold_req > 0) begin
                off.ready   <= 1'b0;
                stall_left  = rx_hold_req - 1;
                rx_hold_req = 0;
            end else if (rx_quiet || r < 70) begin
                off.ready <= 1'b1;
            end else if (r < 96) begin
                off.ready  <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                off.ready  <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    // ---------------------------------------------------------------
    // Neighborhood side
    // ---------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Offer one neighborhood, called and returning at a falling edge
    task automatic send_nbr(input t_nbr n);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            nbr.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        nbr.valid           <= 1'b1;
        nbr.cost_up_left    <= n[P_UL];
        nbr.cost_up         <= n[P_U];
        nbr.cost_up_right   <= n[P_UR];
        nbr.cost_left       <= n[P_L];
        nbr.cost_center     <= n[P_C];
        nbr.cost_right      <= n[P_R];
        nbr.cost_down_left  <= n[P_DL];
        nbr.cost_down       <= n[P_D];
        nbr.cost_down_right <= n[P_DR];
        do @(posedge clk); while (!nbr.ready);
        pending_offsets.push_back(peak_offsets(n));
        @(negedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_offsets_drained();
        nbr.valid <= 1'b0;
        while (pending_offsets.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic t_nbr grid(input int ul, input int u, input int ur,
                                  input int l, input int c, input int r,
                                  input int dl, input int d, input int dr);
        t_nbr n;
        n[P_UL] = ul[COST_W-1:0];
        n[P_U]  = u[COST_W-1:0];
        n[P_UR] = ur[COST_W-1:0];
        n[P_L]  = l[COST_W-1:0];
        n[P_C]  = c[COST_W-1:0];
        n[P_R]  = r[COST_W-1:0];
        n[P_DL] = dl[COST_W-1:0];
        n[P_D]  = d[COST_W-1:0];
        n[P_DR] = dr[COST_W-1:0];
        return n;
    endfunction

    // Eight neighbors summing to five times the center: denominator is zero
    function automatic t_nbr flat_den_nbr();
        t_nbr n;
        int   rem;
        int   left_slots;
        int   lo;
        int   hi;
        n[P_C]     = COST_W'($urandom_range(0, COST_MAX));
        rem        = 5 * int'(n[P_C]);
        left_slots = 8;
        for (int i = 0; i < 9; i++) begin
            if (i != P_C) begin
                lo = rem - COST_MAX * (left_slots - 1);
                if (lo < 0) lo = 0;
                hi = (rem < COST_MAX) ? rem : COST_MAX;
                n[i] = COST_W'($urandom_range(lo, hi));
                rem -= int'(n[i]);
                left_slots--;
            end
        end
        return n;
    endfunction

    function automatic t_nbr random_nbr(input t_shape shape);
        t_nbr n;
        int   p;
        int   v;
        case (shape)
            SHAPE_ANY: begin
                for (int i = 0; i < 9; i++) n[i] = COST_W'($urandom_range(0, COST_MAX));
            end
            SHAPE_VALLEY: begin
                n[P_C] = COST_W'($urandom_range(0, 2000));
                for (int i = 0; i < 9; i++) begin
                    if (i != P_C) begin
                        v = int'(n[P_C]) + $urandom_range(0, 30000);
                        n[i] = COST_W'((v > COST_MAX) ? COST_MAX : v);
                    end
                end
            end
            SHAPE_FLAT_DEN: n = flat_den_nbr();
            SHAPE_NEAR_FLAT: begin
                // One step off a zero denominator: tiny divisor, large offsets
                n = flat_den_nbr();
                p = $urandom_range(0, 8);
                if (n[p] == COST_W'(COST_MAX))
                    n[p] = n[p] - COST_W'(1);
                else if (n[p] == '0 || $urandom_range(0, 1) == 1)
                    n[p] = n[p] + COST_W'(1);
                else
                    n[p] = n[p] - COST_W'(1);
            end
            SHAPE_TINY: begin
                for (int i = 0; i < 9; i++) n[i] = COST_W'($urandom_range(0, 7));
            end
            default: begin
                for (int i = 0; i < 9; i++) begin
                    case ($urandom_range(0, 3))
                        0: n[i] = '0;
                        1: n[i] = COST_W'(1);
                        2: n[i] = COST_W'(COST_MAX - 1);
                        default: n[i] = COST_W'(COST_MAX);
                    endcase
                end
            end
        endcase
        return n;
    endfunction

    function automatic t_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return SHAPE_ANY;
        if (r < 50) return SHAPE_VALLEY;
        if (r < 60) return SHAPE_FLAT_DEN;
        if (r < 80) return SHAPE_NEAR_FLAT;
        if (r < 90) return SHAPE_TINY;
        return SHAPE_RAILS;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_extremes();
        send_nbr(grid(COST_MAX, COST_MAX, COST_MAX, COST_MAX, COST_MAX,
                      COST_MAX, COST_MAX, COST_MAX, COST_MAX));
        send_nbr(grid(0, 0, 0, 0, COST_MAX, 0, 0, 0, 0));
        send_nbr(grid(COST_MAX, COST_MAX, COST_MAX, COST_MAX, 0,
                      COST_MAX, COST_MAX, COST_MAX, COST_MAX));
        send_nbr(grid(COST_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
        send_nbr(grid(0, 0, 0, 0, 0, 0, 0, 0, COST_MAX));
        send_nbr(grid('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA,
                      'h5555, 'hAAAA, 'h5555, 'hAAAA));
        send_nbr(grid('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555,
                      'hAAAA, 'h5555, 'hAAAA, 'h5555));
    endtask

    task automatic test_zero_denominator();
        send_nbr(grid(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_nbr(grid(5, 5, 5, 5, 8, 5, 5, 5, 5));
        // Lopsided neighbors with a zero denominator: numerators are nonzero
        send_nbr(grid(COST_MAX, COST_MAX, COST_MAX, 0, COST_MAX,
                      COST_MAX, 0, 0, COST_MAX));
    endtask

    task automatic test_saturation();
        // Denominator +2 with a large numerator, clipped high and low
        send_nbr(grid(0, COST_MAX - 1, COST_MAX, 0, COST_MAX,
                      COST_MAX, 0, COST_MAX, COST_MAX));
        send_nbr(grid(COST_MAX, COST_MAX - 1, 0, COST_MAX, COST_MAX,
                      0, COST_MAX, COST_MAX, 0));
        // Denominator -2, negative divisor with a clipped quotient
        send_nbr(grid(0, COST_MAX - 4, COST_MAX, 0, COST_MAX - 1,
                      COST_MAX, 0, COST_MAX, COST_MAX));
        // Quotient lands exactly on the low limit, then one past the high limit
        send_nbr(grid(0, 5, 0, 0, 52, 256, 0, 0, 0));
        send_nbr(grid(0, 5, 0, 256, 52, 0, 0, 0, 0));
    endtask

    task automatic test_truncation();
        // Fractional quotients of both signs must round toward zero; the last two divide exactly
        send_nbr(grid(0, 0, 0, 0, 1, 2, 0, 0, 0));
        send_nbr(grid(0, 0, 0, 2, 1, 0, 0, 0, 0));
        send_nbr(grid(0, 0, 0, 0, 0, 0, 0, 3, 1));
        send_nbr(grid(1, 3, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // Output held off while input keeps coming: pipe fills and input stalls
    task automatic test_output_hold();
        tx_quiet    = 1'b1;
        rx_hold_req = 300;
        repeat (80) send_nbr(random_nbr(pick_shape()));
        tx_quiet = 1'b0;
    endtask

    // Back-to-back with no stalls on either side
    task automatic test_streaming();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        repeat (100) send_nbr(random_nbr(pick_shape()));
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Sender pauses until the pipe is empty, then resumes
    task automatic test_drain_pause();
        repeat (20) send_nbr(random_nbr(pick_shape()));
        wait_offsets_drained();
        repeat (20) send_nbr(random_nbr(pick_shape()));
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_nbr(random_nbr(pick_shape()));
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        nbr.valid           = 1'b0;
        nbr.cost_up_left    = '0;
        nbr.cost_up         = '0;
        nbr.cost_up_right   = '0;
        nbr.cost_left       = '0;
        nbr.cost_center     = '0;
        nbr.cost_right      = '0;
        nbr.cost_down_left  = '0;
        nbr.cost_down       = '0;
        nbr.cost_down_right = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_zero_denominator();
        test_saturation();
        test_truncation();
        test_output_hold();
        test_streaming();
        test_drain_pause();
        test_random_mix(710);

        wait_offsets_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
